FILE: hw/rtl/enc_pkg.sv
// enc_pkg: shared types and constants for the even neighbour counter
// used by enc_window, even_neighbour_count_3x3 and the bench
package enc_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W      = 6;
    localparam int ROW_W      = 10;
    localparam int CNT_W      = 4;
    localparam int ROWS_CFG_W = 11;
    localparam int COLS_CFG_W = 7;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int VALUE_W    = 16;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (CNT_W + ROW_W + COL_W);

    // result queue
    localparam int FIFO_AW    = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_AW;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    localparam logic CMD_ELEMENT = 1'b0;
    localparam logic CMD_DRAIN   = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ELEM,
        OP_DRAIN
    } t_op;

    typedef struct packed {
        logic             frame_done;
        logic             run_last;
        logic [COL_W-1:0] cell_column;
        logic [ROW_W-1:0] cell_row;
        logic [CNT_W-1:0] even_count;
    } t_result;

    // window control and the newest column of parity bits
    typedef struct packed {
        logic shift;
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic top;
        logic mid;
        logic bot;
    } t_win_in;

    // counts for: upper cell left of current, upper cell at current,
    // last-row partial left of current, last-row partial at current
    typedef struct packed {
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
        logic [CNT_W-1:0] cnt_p;
        logic [CNT_W-1:0] cnt_e;
    } t_win_cnt;

endpackage

FILE: hw/rtl/enc_ram.sv
// enc_ram: generic single write port ram with registered read
// no dependencies
module enc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                    i_wdata,
    input  logic                                i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                    o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/enc_window.sv
// enc_window: 3x3 parity window (two stored columns plus the newest one)
// and the neighbour counts built from it; uses enc_pkg
module enc_window (
    input  logic               i_clk,
    input  enc_pkg::t_win_in   i_win,
    output enc_pkg::t_win_cnt  o_cnt
);
    import enc_pkg::*;

    // p1 = one column left of the newest, p2 = two columns left
    logic r_top_p1, r_top_p2;
    logic r_mid_p1, r_mid_p2;
    logic r_bot_p1, r_bot_p2;

    function automatic logic [CNT_W-1:0] cnt_bits(input logic [7:0] v);
        logic [CNT_W-1:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + CNT_W'(v[i]);
        end
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_win.shift) begin
            r_top_p2 <= r_top_p1;
            r_top_p1 <= i_win.top;
            r_mid_p2 <= r_mid_p1;
            r_mid_p1 <= i_win.mid;
            r_bot_p2 <= r_bot_p1;
            r_bot_p1 <= i_win.bot;
        end
    end

    logic l1, l2, up;
    assign l1 = i_win.col_ge1;
    assign l2 = i_win.col_ge2;
    assign up = i_win.row_ge2;

    always_comb begin
        // centre row is mid, cell one column left of the newest
        o_cnt.cnt_a = cnt_bits({up & l2 & r_top_p2, up & r_top_p1, up & i_win.top,
                                l2 & r_mid_p2, i_win.mid,
                                l2 & r_bot_p2, r_bot_p1, i_win.bot});
        // centre row is mid, cell at the newest column (row end, no right side)
        o_cnt.cnt_b = cnt_bits({up & l1 & r_top_p1, up & i_win.top,
                                l1 & r_mid_p1, 1'b0,
                                l1 & r_bot_p1, i_win.bot, 2'b00});
        // bottom row as if it were the last row, cell one left of newest
        o_cnt.cnt_p = cnt_bits({i_win.row_ge1 & l2 & r_mid_p2,
                                i_win.row_ge1 & r_mid_p1,
                                i_win.row_ge1 & i_win.mid,
                                l2 & r_bot_p2, i_win.bot, 3'b000});
        // same, cell at the newest column
        o_cnt.cnt_e = cnt_bits({i_win.row_ge1 & l1 & r_mid_p1,
                                i_win.row_ge1 & i_win.mid,
                                l1 & r_bot_p1, 5'b00000});
    end

endmodule

FILE: hw/rtl/even_neighbour_count_3x3.sv
// even_neighbour_count_3x3: streaming count of even moore neighbours
// depends on enc_pkg, enc_ram (line and last-row stores), enc_window
//
// channel   dir  handshake                      content
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata value, tuser cmd
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata counts, tlast, tuser
// cfg       in   i_cfg_we                        i_cfg_index, i_cfg_data
//
// one word accepted per cycle while stage 1 is empty or firing; each result
// passes stage 1 and the result queue; stage 1 waits for two free slots in
// the 4-deep queue, so at row ends (two results) output sets the sustained rate
// synchronous active-low reset clears counters, sizes (to 1) and queue
// stores are not cleared: row flags mask entries not yet written this frame
module even_neighbour_count_3x3 (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [enc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // value[15:0]
    input  logic                              i_s_axis_tuser,  // cmd[0]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // even_count[3:0], cell_row[13:4], cell_column[19:14], zero[23:20]
    output logic [enc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tlast,  // run_last
    output logic                              o_m_axis_tuser,  // frame_done[0]
    input  logic                              i_cfg_we,
    input  logic [enc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [enc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import enc_pkg::*;

    // sizes and frame position
    logic [ROWS_CFG_W-1:0] r_rows_used;
    logic [COLS_CFG_W-1:0] r_cols_used;
    logic [ROW_W-1:0]      r_in_row;
    logic [COL_W-1:0]      r_in_col;
    logic [COL_W-1:0]      r_drain_col;
    logic                  r_frame_loaded;

    // stage 1
    t_op                   r_s1_op;
    logic [ROW_W-1:0]      r_s1_row;
    logic [COL_W-1:0]      r_s1_col;
    logic                  r_s1_even;
    logic                  r_s1_last;
    logic                  r_line_fwd;
    logic [1:0]            r_line_fwd_data;
    logic                  r_part_fwd;
    logic [CNT_W-1:0]      r_part_fwd_data;
    logic [CNT_W-1:0]      r_end_cnt;

    // result queue
    t_result               r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wp;
    logic [FIFO_AW-1:0]    r_rp;
    logic [FIFO_AW:0]      r_cnt;

    logic                  s_accept;
    logic                  s1_busy;
    logic                  s1_fire;
    logic                  elem_ok;
    logic                  drain_ok;
    logic                  in_col_last;
    logic                  in_row_last;
    logic                  drain_done;
    logic [1:0]            line_rdata;
    logic [1:0]            line_eff;
    logic [CNT_W-1:0]      part_rdata;
    logic [CNT_W-1:0]      part_eff;
    logic                  line_we;
    logic [1:0]            line_wdata;
    logic                  part_we;
    logic [COL_W-1:0]      part_waddr;
    t_win_in               win_in;
    t_win_cnt              win_cnt;
    logic                  res_a_v;
    logic                  res_b_v;
    t_result               res_a;
    t_result               res_b;
    t_result               res0;
    t_result               res1;
    logic [1:0]            n_push;
    logic                  pop;
    logic [ROWS_CFG_W-1:0] cfg_rows;
    logic [COLS_CFG_W-1:0] cfg_cols;

    // ---------------- stage 0: handshake and frame position
    assign s1_busy         = (r_s1_op != OP_NONE);
    assign s1_fire         = s1_busy && (r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_s_axis_tready = !s1_busy || s1_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign elem_ok  = (i_s_axis_tuser == CMD_ELEMENT) && !r_frame_loaded;
    assign drain_ok = (i_s_axis_tuser == CMD_DRAIN) && r_frame_loaded;

    assign in_col_last = ((COLS_CFG_W)'(r_in_col) + (COLS_CFG_W)'(1)) >= r_cols_used;
    assign in_row_last = ((ROWS_CFG_W)'(r_in_row) + (ROWS_CFG_W)'(1)) >= r_rows_used;
    assign drain_done  = ((COLS_CFG_W)'(r_drain_col) + (COLS_CFG_W)'(1)) >= r_cols_used;

    // zero counts as one, large values saturate
    always_comb begin
        cfg_rows = i_cfg_data[ROWS_CFG_W-1:0];
        if (cfg_rows == '0) begin
            cfg_rows = (ROWS_CFG_W)'(1);
        end else if (cfg_rows > (ROWS_CFG_W)'(MAX_ROWS)) begin
            cfg_rows = (ROWS_CFG_W)'(MAX_ROWS);
        end
        cfg_cols = i_cfg_data[COLS_CFG_W-1:0];
        if (cfg_cols == '0) begin
            cfg_cols = (COLS_CFG_W)'(1);
        end else if (cfg_cols > (COLS_CFG_W)'(MAX_COLUMNS)) begin
            cfg_cols = (COLS_CFG_W)'(MAX_COLUMNS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used    <= (ROWS_CFG_W)'(1);
            r_cols_used    <= (COLS_CFG_W)'(1);
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_drain_col    <= '0;
            r_frame_loaded <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_COUNT: begin
                    r_rows_used <= cfg_rows;
                end
                REG_COLUMN_COUNT: begin
                    r_cols_used <= cfg_cols;
                end
                default: begin
                end
            endcase
            r_in_row       <= '0;
            r_in_col       <= '0;
            r_drain_col    <= '0;
            r_frame_loaded <= 1'b0;
        end else if (s_accept) begin
            if (elem_ok) begin
                if (in_col_last) begin
                    r_in_col <= '0;
                    if (in_row_last) begin
                        r_frame_loaded <= 1'b1;
                    end else begin
                        r_in_row <= r_in_row + (ROW_W)'(1);
                    end
                end else begin
                    r_in_col <= r_in_col + (COL_W)'(1);
                end
            end else if (drain_ok) begin
                if (drain_done) begin
                    r_in_row       <= '0;
                    r_in_col       <= '0;
                    r_drain_col    <= '0;
                    r_frame_loaded <= 1'b0;
                end else begin
                    r_drain_col <= r_drain_col + (COL_W)'(1);
                end
            end
        end
    end

    // ---------------- stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_op    <= OP_NONE;
            r_line_fwd <= 1'b0;
            r_part_fwd <= 1'b0;
        end else if (s_accept) begin
            if (elem_ok) begin
                r_s1_op <= OP_ELEM;
            end else if (drain_ok) begin
                r_s1_op <= OP_DRAIN;
            end else begin
                r_s1_op <= OP_NONE;
            end
            // the store write of the word now leaving stage 1 is not yet visible
            r_line_fwd <= line_we && (r_s1_col == r_in_col);
            r_part_fwd <= part_we && (part_waddr == r_drain_col);
        end else if (s1_fire) begin
            r_s1_op <= OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_row        <= r_in_row;
            r_s1_col        <= elem_ok ? r_in_col : r_drain_col;
            r_s1_even       <= ~i_s_axis_tdata[0];
            r_s1_last       <= elem_ok ? in_col_last : drain_done;
            r_line_fwd_data <= line_wdata;
            r_part_fwd_data <= win_cnt.cnt_p;
        end
        if (line_we && r_s1_last) begin
            r_end_cnt <= win_cnt.cnt_e;
        end
    end

    // line store: bit 0 = row above, bit 1 = two rows above
    enc_ram #(
        .WIDTH (2),
        .DEPTH (MAX_COLUMNS)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (r_s1_col),
        .i_wdata (line_wdata),
        .i_re    (s_accept),
        .i_raddr (r_in_col),
        .o_rdata (line_rdata)
    );

    // counts for the last row taken without a row below
    enc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_COLUMNS)
    ) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (part_we),
        .i_waddr (part_waddr),
        .i_wdata (win_cnt.cnt_p),
        .i_re    (s_accept),
        .i_raddr (r_drain_col),
        .o_rdata (part_rdata)
    );

    assign line_eff   = r_line_fwd ? r_line_fwd_data : line_rdata;
    assign part_eff   = r_part_fwd ? r_part_fwd_data : part_rdata;
    assign line_we    = s1_fire && (r_s1_op == OP_ELEM);
    assign line_wdata = {line_eff[0], r_s1_even};
    assign part_we    = line_we && (r_s1_col != '0);
    assign part_waddr = r_s1_col - (COL_W)'(1);

    always_comb begin
        win_in.shift   = line_we;
        win_in.row_ge1 = (r_s1_row != '0);
        win_in.row_ge2 = (r_s1_row >= (ROW_W)'(2));
        win_in.col_ge1 = (r_s1_col != '0);
        win_in.col_ge2 = (r_s1_col >= (COL_W)'(2));
        win_in.top     = line_eff[1];
        win_in.mid     = line_eff[0];
        win_in.bot     = r_s1_even;
    end

    enc_window u_window (
        .i_clk (i_clk),
        .i_win (win_in),
        .o_cnt (win_cnt)
    );

    // ---------------- results of stage 1
    assign res_a_v = win_in.row_ge1 && win_in.col_ge1;
    assign res_b_v = win_in.row_ge1 && r_s1_last;

    always_comb begin
        res_a.frame_done  = 1'b0;
        res_a.run_last    = !res_b_v;
        res_a.cell_column = r_s1_col - (COL_W)'(1);
        res_a.cell_row    = r_s1_row - (ROW_W)'(1);
        res_a.even_count  = win_cnt.cnt_a;
        res_b.frame_done  = 1'b0;
        res_b.run_last    = 1'b1;
        res_b.cell_column = r_s1_col;
        res_b.cell_row    = r_s1_row - (ROW_W)'(1);
        res_b.even_count  = win_cnt.cnt_b;
        res0   = res_a;
        res1   = res_b;
        n_push = 2'd0;
        case (r_s1_op)
            OP_ELEM: begin
                if (res_a_v) begin
                    n_push = res_b_v ? 2'd2 : 2'd1;
                end else if (res_b_v) begin
                    res0   = res_b;
                    n_push = 2'd1;
                end
            end
            OP_DRAIN: begin
                res0.frame_done  = r_s1_last;
                res0.run_last    = 1'b1;
                res0.cell_column = r_s1_col;
                res0.cell_row    = r_s1_row;
                res0.even_count  = r_s1_last ? r_end_cnt : part_eff;
                n_push           = 2'd1;
            end
            default: begin
            end
        endcase
        if (!s1_fire) begin
            n_push = 2'd0;
        end
    end

    // ---------------- result queue
    assign pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wp] <= res0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wp + (FIFO_AW)'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + (FIFO_AW)'(n_push);
            r_rp  <= r_rp + (FIFO_AW)'(pop);
            r_cnt <= r_cnt + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_fifo[r_rp].cell_column,
                              r_fifo[r_rp].cell_row, r_fifo[r_rp].even_count};
    assign o_m_axis_tlast  = r_fifo[r_rp].run_last;
    assign o_m_axis_tuser  = r_fifo[r_rp].frame_done;

    // ---------------- checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_loaded |-> (r_in_col == '0))
        else $error("loaded frame with nonzero input column");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain_col != '0) |-> r_frame_loaded)
        else $error("drain position moved before frame loaded");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_op == OP_DRAIN) |-> ((COLS_CFG_W)'(r_s1_col) < r_cols_used))
        else $error("drain column beyond row");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("frame end word without run end");

endmodule

FILE: dv/even_neighbour_count_3x3_tb.sv
// even_neighbour_count_3x3_tb: self-checking bench for the even neighbour counter
// sends element and drain words with random idling on both stream sides and checks
// every result against a parity-store predictor or a fixed expected word; needs enc_pkg and the rtl
module even_neighbour_count_3x3_tb;
    import enc_pkg::*;

    localparam int TOTAL_ITEMS  = 1250;
    localparam int TALL_ITEMS   = MAX_ROWS + 1;
    localparam int RANDOM_ITEMS = TOTAL_ITEMS - TALL_ITEMS;
    localparam int DIR_ROWS     = 30;
    localparam int SETTLE       = 6;
    localparam int HOLD_CYCLES  = 120;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  cmd;
        logic [VALUE_W-1:0]    value;
        logic                  typed;
        t_result               want;
    } t_stim_row;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_valid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data   = '0;
    logic                   s_cmd    = CMD_ELEMENT;
    logic                   m_ready  = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = REG_ROW_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   m_last;
    logic                   m_user;

    // predictor state: "is even" bits of three rows, frame position and sizes
    bit                    even_bits [3*MAX_COLUMNS];
    logic [ROWS_CFG_W-1:0] row_reg = ROWS_CFG_W'(1);
    logic [COLS_CFG_W-1:0] col_reg = COLS_CFG_W'(1);
    int unsigned           at_row = 0;
    int unsigned           at_col = 0;
    int unsigned           drain_col = 0;
    bit                    loaded = 1'b0;

    t_result     pending_counts [$];
    t_result     step_results [$];
    int unsigned mismatch_count = 0;
    int unsigned item_count = 0;
    bit          hold_req = 1'b0;
    bit          steady = 1'b0;

    even_neighbour_count_3x3 DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_cmd),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last),
        .o_m_axis_tuser (m_user),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #200000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned rows_eff();
        if (row_reg == 0) return 1;
        if (row_reg > MAX_ROWS) return MAX_ROWS;
        return 32'(row_reg);
    endfunction

    function automatic int unsigned cols_eff();
        if (col_reg == 0) return 1;
        if (col_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return 32'(col_reg);
    endfunction

    function automatic int unsigned even_bit(input int unsigned r, input int unsigned c);
        return 32'(even_bits[(r % 3) * MAX_COLUMNS + (c % MAX_COLUMNS)]);
    endfunction

    // cells outside the matrix are border and never counted
    function automatic logic [CNT_W-1:0] even_around(input int unsigned r,
                                                     input int unsigned c,
                                                     input bit has_down);
        bit          lft;
        bit          rgt;
        int unsigned n;
        lft = (c >= 1);
        rgt = (c + 1 < cols_eff());
        n = 0;
        if (r >= 1) begin
            if (lft) n += even_bit(r - 1, c - 1);
            n += even_bit(r - 1, c);
            if (rgt) n += even_bit(r - 1, c + 1);
        end
        if (lft) n += even_bit(r, c - 1);
        if (rgt) n += even_bit(r, c + 1);
        if (has_down) begin
            if (lft) n += even_bit(r + 1, c - 1);
            n += even_bit(r + 1, c);
            if (rgt) n += even_bit(r + 1, c + 1);
        end
        return n[CNT_W-1:0];
    endfunction

    function automatic t_result make_count(input logic [CNT_W-1:0] cnt, input int unsigned r,
                                           input int unsigned c, input bit done);
        t_result res;
        res = '0;
        res.even_count  = cnt;
        res.cell_row    = r[ROW_W-1:0];
        res.cell_column = c[COL_W-1:0];
        res.frame_done  = done;
        return res;
    endfunction

    function automatic void clear_position();
        at_row    = 0;
        at_col    = 0;
        drain_col = 0;
        loaded    = 1'b0;
    endfunction

    // results caused by one accepted word; used is low when the word is ignored
    task automatic predict_word(input logic cmd, input logic [VALUE_W-1:0] value,
                                output bit used);
        int unsigned r;
        int unsigned c;
        bit          done;
        t_result     tail;
        step_results.delete();
        used = 1'b0;
        if (cmd == CMD_ELEMENT) begin
            if (loaded) return;
            used = 1'b1;
            r = at_row;
            c = at_col;
            even_bits[(r % 3) * MAX_COLUMNS + (c % MAX_COLUMNS)] = ~value[0];
            if (r >= 1) begin
                if (c >= 1)
                    step_results.push_back(make_count(even_around(r - 1, c - 1, 1'b1),
                                                      r - 1, c - 1, 1'b0));
                if (c + 1 == cols_eff())
                    step_results.push_back(make_count(even_around(r - 1, c, 1'b1),
                                                      r - 1, c, 1'b0));
            end
            if (c + 1 >= cols_eff()) begin
                at_col = 0;
                if (r + 1 >= rows_eff()) loaded = 1'b1;
                else at_row = r + 1;
            end else begin
                at_col = c + 1;
            end
        end else begin
            if (!loaded) return;
            used = 1'b1;
            done = (drain_col + 1 >= cols_eff());
            step_results.push_back(make_count(even_around(at_row, drain_col, 1'b0),
                                              at_row, drain_col, done));
            if (done) clear_position();
            else drain_col = drain_col + 1;
        end
        if (step_results.size() != 0) begin
            tail = step_results.pop_back();
            tail.run_last = 1'b1;
            step_results.push_back(tail);
        end
    endtask

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_stim_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic t_stim_row word_row(input logic cmd, input logic [VALUE_W-1:0] value);
        t_stim_row row;
        row = '0;
        row.cmd   = cmd;
        row.value = value;
        return row;
    endfunction

    function automatic t_stim_row chk_row(input logic cmd, input logic [VALUE_W-1:0] value,
                                          input int unsigned cnt, input int unsigned r,
                                          input int unsigned c, input bit done);
        t_stim_row row;
        row = word_row(cmd, value);
        row.typed = 1'b1;
        row.want  = make_count(cnt[CNT_W-1:0], r, c, done);
        row.want.run_last = 1'b1;
        return row;
    endfunction

    function automatic logic [VALUE_W-1:0] parity_value(input int unsigned even_pct);
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom);
        v[0] = ($urandom_range(99) < even_pct) ? 1'b0 : 1'b1;
        return v;
    endfunction

    // registers are written only with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROW_COUNT) row_reg = data[ROWS_CFG_W-1:0];
        else col_reg = data[COLS_CFG_W-1:0];
        clear_position();
    endtask

    task automatic push_word(input logic cmd, input logic [VALUE_W-1:0] value,
                             input logic typed, input t_result typed_res);
        bit used;
        while (!steady && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_data  <= value;
        do @(posedge clk); while (!s_ready);
        predict_word(cmd, value, used);
        if (typed) pending_counts.push_back(typed_res);
        else foreach (step_results[i]) pending_counts.push_back(step_results[i]);
        if (used) begin
            item_count++;
            if (item_count == 300) hold_req = 1'b1;
            steady = (item_count >= 600 && item_count < 800);
        end
    endtask

    // output side: random stalls, one long hold-off while words keep coming
    initial begin : sink
        int unsigned hold_left;
        bit          hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    function automatic void field_check(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            got = '0;
            got.even_count  = m_data[CNT_W-1:0];
            got.cell_row    = m_data[CNT_W +: ROW_W];
            got.cell_column = m_data[CNT_W+ROW_W +: COL_W];
            got.run_last    = m_last;
            got.frame_done  = m_user;
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = pending_counts.pop_front();
                field_check("even_count", 32'(want.even_count), 32'(got.even_count));
                field_check("cell_row", 32'(want.cell_row), 32'(got.cell_row));
                field_check("cell_column", 32'(want.cell_column), 32'(got.cell_column));
                field_check("run_last", 32'(want.run_last), 32'(got.run_last));
                field_check("frame_done", 32'(want.frame_done), 32'(got.frame_done));
            end
        end
    end

    initial begin : stimulus
        t_stim_row             dir_tab [DIR_ROWS];
        int unsigned           k;
        int unsigned           e;
        int unsigned           pick;
        int unsigned           rows_n;
        int unsigned           cols_n;
        int unsigned           cut;
        int unsigned           pct;
        logic [CFG_DATA_W-1:0] rows_cfg;
        logic [CFG_DATA_W-1:0] cols_cfg;
        bit                    force_cfg;

        dir_tab = '{
            // after reset the frame is a single cell
            word_row(CMD_DRAIN, 16'h0000),
            word_row(CMD_ELEMENT, 16'h8000),
            word_row(CMD_ELEMENT, 16'h7FFF),
            chk_row(CMD_DRAIN, 16'hFFFF, 0, 0, 0, 1'b1),
            // zero rows counts as one: single row of three
            cfg_row(REG_ROW_COUNT, 11'd0),
            cfg_row(REG_COLUMN_COUNT, 11'd3),
            word_row(CMD_ELEMENT, 16'hFFFE),
            word_row(CMD_ELEMENT, 16'h7FFF),
            word_row(CMD_ELEMENT, 16'h0000),
            chk_row(CMD_DRAIN, 16'h0001, 0, 0, 0, 1'b0),
            chk_row(CMD_DRAIN, 16'hAAAA, 2, 0, 1, 1'b0),
            chk_row(CMD_DRAIN, 16'h5555, 0, 0, 2, 1'b1),
            // 2x2: the last element emits two words
            cfg_row(REG_ROW_COUNT, 11'd2),
            cfg_row(REG_COLUMN_COUNT, 11'd2),
            word_row(CMD_ELEMENT, 16'h0002),
            word_row(CMD_ELEMENT, 16'h0004),
            word_row(CMD_ELEMENT, 16'h0006),
            word_row(CMD_ELEMENT, 16'h8002),
            // 3x3 all even: the center sees eight
            cfg_row(REG_ROW_COUNT, 11'd3),
            cfg_row(REG_COLUMN_COUNT, 11'd3),
            word_row(CMD_ELEMENT, 16'hFFFE),
            word_row(CMD_ELEMENT, 16'h8000),
            word_row(CMD_ELEMENT, 16'h7FFE),
            word_row(CMD_ELEMENT, 16'h5554),
            word_row(CMD_ELEMENT, 16'hAAAA),
            word_row(CMD_ELEMENT, 16'h0000),
            word_row(CMD_ELEMENT, 16'h0002),
            word_row(CMD_ELEMENT, 16'h0100),
            word_row(CMD_ELEMENT, 16'hF0F0),
            word_row(CMD_DRAIN, 16'hFFFF)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            if (dir_tab[k].is_cfg) write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
            else push_word(dir_tab[k].cmd, dir_tab[k].value, dir_tab[k].typed,
                           dir_tab[k].want);
        end

        // random frames leave room for the tallest frame at the end
        force_cfg = 1'b1;
        while (item_count < RANDOM_ITEMS) begin
            if (force_cfg || $urandom_range(0, 9) < 6) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    rows_cfg = '0;
                    cols_cfg = CFG_DATA_W'($urandom_range(1, 8));
                end else if (pick == 1) begin
                    // widest rows, written as is or saturated
                    rows_cfg = CFG_DATA_W'($urandom_range(1, 3));
                    cols_cfg = $urandom_range(0, 1) ? CFG_DATA_W'(64) : CFG_DATA_W'(127);
                end else if (pick == 2) begin
                    rows_cfg = CFG_DATA_W'($urandom_range(8, 24));
                    cols_cfg = CFG_DATA_W'($urandom_range(0, 2));
                end else begin
                    rows_cfg = CFG_DATA_W'($urandom_range(1, 6));
                    cols_cfg = CFG_DATA_W'($urandom_range(0, 9));
                end
                if ($urandom_range(0, 1)) begin
                    write_reg(REG_ROW_COUNT, rows_cfg);
                    write_reg(REG_COLUMN_COUNT, cols_cfg);
                end else begin
                    write_reg(REG_COLUMN_COUNT, cols_cfg);
                    write_reg(REG_ROW_COUNT, rows_cfg);
                end
            end
            force_cfg = 1'b0;
            rows_n = rows_eff();
            cols_n = cols_eff();
            case ($urandom_range(0, 3))
                0: pct = 10;
                1: pct = 90;
                default: pct = 50;
            endcase
            // drain before the frame is loaded is dropped
            if ($urandom_range(0, 4) == 0) push_word(CMD_DRAIN, parity_value(50), 1'b0, '0);
            cut = rows_n * cols_n;
            if ($urandom_range(0, 24) == 0) begin
                cut = $urandom_range(0, rows_n * cols_n - 1);
                force_cfg = 1'b1;
            end
            for (e = 0; e < cut; e++) push_word(CMD_ELEMENT, parity_value(pct), 1'b0, '0);
            if (!force_cfg) begin
                for (e = 0; e < cols_n; e++) begin
                    // element while the last row waits is dropped
                    if ($urandom_range(0, 9) == 0)
                        push_word(CMD_ELEMENT, parity_value(50), 1'b0, '0);
                    push_word(CMD_DRAIN, parity_value(50), 1'b0, '0);
                end
            end
        end

        // tallest frame: row count saturates to the maximum
        write_reg(REG_ROW_COUNT, 11'h7FF);
        write_reg(REG_COLUMN_COUNT, 11'd1);
        rows_n = rows_eff();
        for (e = 0; e < rows_n; e++) push_word(CMD_ELEMENT, parity_value(50), 1'b0, '0);
        push_word(CMD_DRAIN, parity_value(50), 1'b0, '0);

        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/enc_pkg.sv
hw/rtl/enc_ram.sv
hw/rtl/enc_window.sv
hw/rtl/even_neighbour_count_3x3.sv
dv/even_neighbour_count_3x3_tb.sv
